// ===== hdl/racd_pkg.sv =====
// Shared types and constants for the recovery arm-and-deploy controller.
`timescale 1ns / 1ps
package racd_pkg;

  localparam int unsigned LONG_W         = 8;
  localparam int unsigned DELAY_MS_W     = 13;
  localparam logic [LONG_W-1:0] LONG_RESET_TICKS = LONG_W'(50);

  // Button events seen in one poll tick.
  typedef struct packed {
    logic click;
    logic long_press;
  } btn_evt_t;

  // Servo commands carried in a result transaction.
  typedef enum logic [1:0] {
    SERVO_NONE   = 2'd0,
    SERVO_LOCK   = 2'd1,
    SERVO_DEPLOY = 2'd2
  } servo_t;

endpackage

// ===== hdl/racd_if.sv =====
// Channel interfaces: poll ticks in, results out, configuration writes.
`timescale 1ns / 1ps
interface racd_poll_if;
  logic valid;
  logic ready;
  logic button_pressed;
  logic launch_sensed;
  modport source (output valid, output button_pressed, output launch_sensed, input ready);
  modport sink   (input valid, input button_pressed, input launch_sensed, output ready);
endinterface

interface racd_result_if;
  logic        valid;
  logic        ready;
  logic        led_locked_on;
  logic        led_armed_on;
  logic        led_launch_on;
  logic [1:0]  servo_action;
  logic        beep_request;
  logic [1:0]  mode_now;
  logic [12:0] delay_setting_ms;
  modport source (output valid, output led_locked_on, output led_armed_on,
                  output led_launch_on, output servo_action, output beep_request,
                  output mode_now, output delay_setting_ms, input ready);
  modport sink   (input valid, input led_locked_on, input led_armed_on,
                  input led_launch_on, input servo_action, input beep_request,
                  input mode_now, input delay_setting_ms, output ready);
endinterface

interface racd_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] long_press_ticks;
  modport source (output valid, output long_press_ticks, input ready);
  modport sink   (input valid, input long_press_ticks, output ready);
endinterface

// ===== hdl/racd_button.sv =====
// Button classifier: short click on release, long press after a held threshold.
`timescale 1ns / 1ps
module racd_button
  import racd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              pushed,
  input  logic [LONG_W-1:0] long_ticks,
  output btn_evt_t          evt
);

  logic              was_pressed;
  logic              click_pending;
  logic [LONG_W-1:0] hold_count;
  logic [LONG_W:0]   hold_next;

  // Compare one bit wider so the top threshold never wraps.
  assign hold_next      = {1'b0, hold_count} + (LONG_W+1)'(1);
  assign evt.click      = was_pressed & ~pushed & click_pending;
  assign evt.long_press = was_pressed & pushed & (hold_next > {1'b0, long_ticks});

  always_ff @(posedge clk) begin
    if (rst) begin
      was_pressed   <= 1'b0;
      click_pending <= 1'b0;
      hold_count    <= '0;
    end else if (en) begin
      was_pressed <= pushed;
      if (!was_pressed && pushed) begin
        hold_count    <= '0;
        click_pending <= 1'b1;
      end else if (was_pressed && !pushed) begin
        click_pending <= 1'b0;
      end else if (pushed) begin
        if (evt.long_press) begin
          click_pending <= 1'b0;
          hold_count    <= '0;
        end else begin
          hold_count <= hold_next[LONG_W-1:0];
        end
      end
    end
  end

endmodule

// ===== hdl/recovery_arm_and_deploy_controller.sv =====
// Top level: mode machine, programming display and result register.
// The result is registered: its transaction is offered in the cycle after the poll tick is accepted.
// Throughput: one poll tick per cycle; the result register holds while the
//   sink stalls and a new tick is taken in the same cycle the old result leaves.
// Reset (rst, synchronous): mode idle, LEDs off, delay 2000 ms, threshold 50.
`timescale 1ns / 1ps
module recovery_arm_and_deploy_controller
  import racd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  racd_poll_if.sink            poll,
  racd_result_if.source        result,
  racd_cfg_if.sink             cfg
);

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_LOCKED = 2'd1,
    MODE_ARMED  = 2'd2,
    MODE_PROG   = 2'd3
  } mode_t;

  localparam int unsigned TICK_MS        = 20;
  localparam int unsigned SEC_MS         = 1000;
  localparam int unsigned BLINK_ON_MS    = 750;
  localparam int unsigned TICKS_PER_SEC  = SEC_MS / TICK_MS;
  localparam int unsigned BLINK_TICKS    = (BLINK_ON_MS + TICK_MS - 1) / TICK_MS;
  localparam int unsigned CYCLE_SEC      = 6;
  localparam int unsigned DELAY_MAX_SEC  = CYCLE_SEC - 1;
  localparam int unsigned DELAY_RESET_S  = 2;
  localparam int unsigned TICK_W         = $clog2(TICKS_PER_SEC);
  localparam int unsigned SEC_W          = $clog2(CYCLE_SEC + 1);

  localparam int unsigned LOCK_BIT   = 0;
  localparam int unsigned ARM_BIT    = 1;
  localparam int unsigned LAUNCH_BIT = 2;

  logic              accept;
  logic [LONG_W-1:0] long_ticks;
  btn_evt_t          evt;

  mode_t             mode, mode_next;
  logic [2:0]        led_bits, led_next;
  logic [SEC_W-1:0]  delay_sec, delay_sec_next;   // delay in whole seconds
  logic [SEC_W-1:0]  disp_sec, disp_sec_next;     // display time, seconds part
  logic [TICK_W-1:0] disp_tick, disp_tick_next;   // display time, ticks within second
  servo_t            servo;
  logic              beep;

  logic [SEC_W-1:0]  sec_base, sec_inc;
  logic [TICK_W-1:0] tick_base, tick_inc;

  assign poll.ready = ~result.valid | result.ready;
  assign accept     = poll.valid & poll.ready;
  assign cfg.ready  = 1'b1;

  racd_button u_button (
    .clk        (clk),
    .rst        (rst),
    .en         (accept),
    .pushed     (poll.button_pressed),
    .long_ticks (long_ticks),
    .evt        (evt)
  );

  // Advance the display clock by one tick, restarting on a click.
  always_comb begin
    sec_base  = evt.click ? '0 : disp_sec;
    tick_base = evt.click ? '0 : disp_tick;
    if (tick_base == TICK_W'(TICKS_PER_SEC - 1)) begin
      tick_inc = '0;
      sec_inc  = sec_base + SEC_W'(1);
    end else begin
      tick_inc = tick_base + TICK_W'(1);
      sec_inc  = sec_base;
    end
  end

  always_comb begin
    mode_next      = mode;
    led_next       = led_bits;
    delay_sec_next = delay_sec;
    disp_sec_next  = disp_sec;
    disp_tick_next = disp_tick;
    servo          = SERVO_NONE;
    beep           = 1'b0;
    unique case (mode)
      MODE_IDLE: begin
        if (evt.click) begin
          servo              = SERVO_LOCK;
          beep               = 1'b1;
          mode_next          = MODE_LOCKED;
          led_next[LOCK_BIT] = 1'b1;
        end else if (evt.long_press) begin
          led_next[LAUNCH_BIT] = 1'b1;
          mode_next            = MODE_PROG;
          disp_sec_next        = '0;
          disp_tick_next       = '0;
        end
      end
      MODE_LOCKED: begin
        if (evt.click) begin
          beep              = 1'b1;
          mode_next         = MODE_ARMED;
          led_next[ARM_BIT] = 1'b1;
        end
      end
      MODE_ARMED: begin
        if (poll.launch_sensed) begin
          servo     = SERVO_DEPLOY;
          led_next  = '0;
          mode_next = MODE_IDLE;
        end
      end
      MODE_PROG: begin
        if (evt.long_press) begin
          led_next  = '0;
          mode_next = MODE_IDLE;
        end else begin
          if (evt.click) begin
            delay_sec_next = (delay_sec == SEC_W'(DELAY_MAX_SEC)) ? '0
                                                                 : delay_sec + SEC_W'(1);
          end
          // Lit during the first part of each second, for delay seconds.
          led_next[LOCK_BIT] = (tick_inc < TICK_W'(BLINK_TICKS)) &&
                               (sec_inc < delay_sec_next);
          disp_tick_next = tick_inc;
          disp_sec_next  = (sec_inc == SEC_W'(CYCLE_SEC)) ? '0 : sec_inc;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      long_ticks <= LONG_RESET_TICKS;
      mode       <= MODE_IDLE;
      led_bits   <= '0;
      delay_sec  <= SEC_W'(DELAY_RESET_S);
      disp_sec   <= '0;
      disp_tick  <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        long_ticks <= cfg.long_press_ticks;
      end
      if (accept) begin
        mode      <= mode_next;
        led_bits  <= led_next;
        delay_sec <= delay_sec_next;
        disp_sec  <= disp_sec_next;
        disp_tick <= disp_tick_next;
      end
    end
  end

  // Result register: hold until the sink takes the transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (accept) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.led_locked_on    <= led_next[LOCK_BIT];
      result.led_armed_on     <= led_next[ARM_BIT];
      result.led_launch_on    <= led_next[LAUNCH_BIT];
      result.servo_action     <= servo;
      result.beep_request     <= beep;
      result.mode_now         <= mode_next;
      result.delay_setting_ms <= DELAY_MS_W'(delay_sec_next) * DELAY_MS_W'(SEC_MS);
    end
  end

  // Programming mode always shows the programming indicator.
  a_prog_led: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.mode_now == MODE_PROG |-> result.led_launch_on)
    else $error("programming result without launch LED");

  // A deploy ends the tick in idle with all LEDs dark.
  a_deploy_idle: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.servo_action == SERVO_DEPLOY |->
      result.mode_now == MODE_IDLE && !result.led_locked_on &&
      !result.led_armed_on && !result.led_launch_on)
    else $error("deploy result not idle with LEDs off");

  // Tones only accompany entry into locked or armed.
  a_beep_mode: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.beep_request |->
      result.mode_now == MODE_LOCKED || result.mode_now == MODE_ARMED)
    else $error("beep outside locked or armed entry");

  // A stalled result keeps its mode and delay setting while the next tick waits.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=> result.valid && $stable(result.mode_now) &&
      $stable(result.delay_setting_ms))
    else $error("stalled result changed");

  // Delay setting stays within the programmable range and display time within its cycle.
  a_delay_range: assert property (@(posedge clk) disable iff (rst)
    delay_sec <= SEC_W'(DELAY_MAX_SEC) && disp_sec < SEC_W'(CYCLE_SEC))
    else $error("delay or display time out of range");

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the recovery arm-and-deploy controller.
`timescale 1ns / 1ps
module tb
  import racd_pkg::*;
();

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_LOCKED = 2'd1,
    MODE_ARMED  = 2'd2,
    MODE_PROG   = 2'd3
  } ctl_mode_e;

  localparam int DELAY_STEP_MS    = 1000;
  localparam int DISPLAY_CYCLE_MS = 6000;
  localparam int BLINK_PERIOD_MS  = 1000;
  localparam int BLINK_ON_MS      = 750;
  localparam int TICK_MS          = 20;
  localparam int DELAY_RESET_MS   = 2000;
  localparam int MAX_REPORTS      = 30;

  typedef struct packed {
    logic button;
    logic launch;
  } tick_t;

  typedef struct packed {
    logic        lock_led;
    logic        arm_led;
    logic        launch_led;
    logic [1:0]  servo;
    logic        beep;
    logic [1:0]  mode;
    logic [12:0] delay_ms;
  } status_t;

  logic clk;
  logic rst;

  racd_poll_if   poll();
  racd_result_if result();
  racd_cfg_if    cfg();

  recovery_arm_and_deploy_controller u_top (
    .clk    (clk),
    .rst    (rst),
    .poll   (poll),
    .result (result),
    .cfg    (cfg)
  );

  // Controller model state.
  logic [LONG_W-1:0] long_thresh = LONG_RESET_TICKS;
  ctl_mode_e         ctl_mode    = MODE_IDLE;
  logic              prev_button = 1'b0;
  logic              click_open  = 1'b0;
  logic [7:0]        held_ticks  = 8'd0;
  int                delay_ms    = DELAY_RESET_MS;
  int                blink_ms    = 0;
  logic              led_lock    = 1'b0;
  logic              led_arm     = 1'b0;
  logic              led_fly     = 1'b0;

  tick_t   pending_ticks[$];
  status_t predicted_status[$];
  tick_t   next_tick;
  int      tick_gap;
  int      sink_stall;
  int      phase_ticks;
  int      fail_count;
  bit      steady;

  logic [1:0] directed_seq [24] = '{
    2'b01, 2'b10, 2'b00, 2'b01, 2'b11, 2'b00, 2'b00, 2'b01,
    2'b10, 2'b10, 2'b10, 2'b00, 2'b10, 2'b00, 2'b10, 2'b00,
    2'b10, 2'b00, 2'b10, 2'b00, 2'b10, 2'b10, 2'b10, 2'b00
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic status_t advance_controller(input logic pushed, input logic launch);
    logic    click;
    logic    long_hit;
    logic    beep;
    servo_t  servo;
    int      nxt;
    status_t s;
    click    = 1'b0;
    long_hit = 1'b0;
    beep     = 1'b0;
    servo    = SERVO_NONE;
    // button classifier
    if (!prev_button && pushed) begin
      held_ticks = 8'd0;
      click_open = 1'b1;
    end else if (prev_button && !pushed) begin
      if (click_open) begin
        click      = 1'b1;
        click_open = 1'b0;
      end
    end else if (pushed) begin
      // one bit wider than the counter, so a threshold of 255 needs 256 ticks
      nxt = int'(held_ticks) + 1;
      if (nxt > int'(long_thresh)) begin
        long_hit   = 1'b1;
        click_open = 1'b0;
        held_ticks = 8'd0;
      end else begin
        held_ticks = 8'(nxt);
      end
    end
    prev_button = pushed;

    case (ctl_mode)
      MODE_IDLE: begin
        if (click) begin
          servo    = SERVO_LOCK;
          beep     = 1'b1;
          ctl_mode = MODE_LOCKED;
          led_lock = 1'b1;
        end else if (long_hit) begin
          led_fly  = 1'b1;
          ctl_mode = MODE_PROG;
          blink_ms = 0;
        end
      end
      MODE_LOCKED: begin
        if (click) begin
          beep     = 1'b1;
          ctl_mode = MODE_ARMED;
          led_arm  = 1'b1;
        end
      end
      MODE_ARMED: begin
        if (launch) begin
          servo    = SERVO_DEPLOY;
          led_lock = 1'b0;
          led_arm  = 1'b0;
          led_fly  = 1'b0;
          ctl_mode = MODE_IDLE;
        end
      end
      MODE_PROG: begin
        if (long_hit) begin
          // leave programming with no display update
          led_lock = 1'b0;
          led_arm  = 1'b0;
          led_fly  = 1'b0;
          ctl_mode = MODE_IDLE;
        end else begin
          if (click) begin
            delay_ms = (delay_ms + DELAY_STEP_MS) % DISPLAY_CYCLE_MS;
            blink_ms = 0;
          end
          blink_ms += TICK_MS;
          led_lock = ((blink_ms % BLINK_PERIOD_MS) < BLINK_ON_MS) && (blink_ms < delay_ms);
          blink_ms = blink_ms % DISPLAY_CYCLE_MS;
        end
      end
    endcase

    s.lock_led   = led_lock;
    s.arm_led    = led_arm;
    s.launch_led = led_fly;
    s.servo      = servo;
    s.beep       = beep;
    s.mode       = ctl_mode;
    s.delay_ms   = 13'(delay_ms);
    return s;
  endfunction

  function automatic int random_pause();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < MAX_REPORTS)
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_status();
    status_t got;
    status_t want;
    got.lock_led   = result.led_locked_on;
    got.arm_led    = result.led_armed_on;
    got.launch_led = result.led_launch_on;
    got.servo      = result.servo_action;
    got.beep       = result.beep_request;
    got.mode       = result.mode_now;
    got.delay_ms   = result.delay_setting_ms;
    if (predicted_status.size() == 0) begin
      report_mismatch("result transaction with no poll tick pending");
      return;
    end
    want = predicted_status.pop_front();
    if (got.lock_led !== want.lock_led)
      report_mismatch($sformatf("led_locked_on got %b want %b", got.lock_led, want.lock_led));
    if (got.arm_led !== want.arm_led)
      report_mismatch($sformatf("led_armed_on got %b want %b", got.arm_led, want.arm_led));
    if (got.launch_led !== want.launch_led)
      report_mismatch($sformatf("led_launch_on got %b want %b", got.launch_led,
                                want.launch_led));
    if (got.servo !== want.servo)
      report_mismatch($sformatf("servo_action got %0d want %0d", got.servo, want.servo));
    if (got.beep !== want.beep)
      report_mismatch($sformatf("beep_request got %b want %b", got.beep, want.beep));
    if (got.mode !== want.mode)
      report_mismatch($sformatf("mode_now got %0d want %0d", got.mode, want.mode));
    if (got.delay_ms !== want.delay_ms)
      report_mismatch($sformatf("delay_setting_ms got %0d want %0d", got.delay_ms, want.delay_ms));
  endtask

  // Poll tick driver: predict on acceptance, then present the next tick.
  always @(posedge clk) begin
    if (rst) begin
      poll.valid          <= 1'b0;
      poll.button_pressed <= 1'b0;
      poll.launch_sensed  <= 1'b0;
      tick_gap            <= 0;
    end else begin
      if (poll.valid && poll.ready)
        predicted_status.push_back(advance_controller(poll.button_pressed, poll.launch_sensed));
      if (!poll.valid || poll.ready) begin
        if (tick_gap != 0) begin
          tick_gap   <= tick_gap - 1;
          poll.valid <= 1'b0;
        end else if (pending_ticks.size() != 0) begin
          next_tick            = pending_ticks.pop_front();
          poll.valid          <= 1'b1;
          poll.button_pressed <= next_tick.button;
          poll.launch_sensed  <= next_tick.launch;
          tick_gap            <= random_pause();
        end else begin
          poll.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
      sink_stall   <= 0;
    end else begin
      if (result.valid && result.ready)
        check_status();
      if (sink_stall != 0) begin
        sink_stall   <= sink_stall - 1;
        result.ready <= 1'b0;
      end else begin
        result.ready <= 1'b1;
        if ($urandom_range(0, 7) == 0)
          sink_stall <= random_pause();
      end
    end
  end

  task automatic push_ticks(input logic button, input int n, input bit launch_ok);
    tick_t t;
    repeat (n) begin
      t.button = button;
      t.launch = launch_ok ? ($urandom_range(0, 15) == 0) : 1'b0;
      pending_ticks.push_back(t);
    end
    phase_ticks += n;
  endtask

  task automatic gesture_click(input int thr);
    int k;
    // hold up to exactly the threshold now and then: still a click
    k = ($urandom_range(0, 7) == 0) ? thr : $urandom_range(0, (thr < 4) ? thr : 4);
    push_ticks(1'b1, 1 + k, 1'b1);
    push_ticks(1'b0, $urandom_range(1, 4), 1'b1);
  endtask

  task automatic gesture_long(input int thr);
    push_ticks(1'b1, thr + 2 + $urandom_range(0, 3), 1'b1);
    push_ticks(1'b0, $urandom_range(1, 4), 1'b1);
  endtask

  task automatic build_phase(input int thr, input int target);
    int r;
    int n;
    tick_t t;
    phase_ticks = 0;
    while (phase_ticks < target) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        // lock, arm, then launch
        gesture_click(thr);
        push_ticks(1'b0, $urandom_range(1, 20), 1'b0);
        gesture_click(thr);
        push_ticks(1'b0, $urandom_range(1, 20), 1'b0);
        t.button = 1'b0;
        t.launch = 1'b1;
        pending_ticks.push_back(t);
        phase_ticks++;
      end else if (r < 60) begin
        // enter programming, step the delay, let the display run, leave
        gesture_long(thr);
        n = $urandom_range(0, 7);
        repeat (n) begin
          gesture_click(thr);
          push_ticks(1'b0, ($urandom_range(0, 3) == 0) ? $urandom_range(50, 320)
                                                       : $urandom_range(1, 30), 1'b1);
        end
        gesture_long(thr);
      end else if (r < 70) begin
        gesture_click(thr);
      end else if (r < 80) begin
        gesture_long(thr);
      end else begin
        repeat ($urandom_range(1, 12))
          push_ticks(1'($urandom_range(0, 1)), $urandom_range(1, 6), 1'b1);
      end
    end
    // trim the phase to its budget of poll ticks
    while (pending_ticks.size() > target)
      void'(pending_ticks.pop_back());
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_ticks.size() != 0 || poll.valid || predicted_status.size() != 0);
  endtask

  task automatic write_threshold(input logic [LONG_W-1:0] value);
    @(posedge clk);
    cfg.valid            <= 1'b1;
    cfg.long_press_ticks <= value;
    do @(posedge clk);
    while (!cfg.ready);
    cfg.valid   <= 1'b0;
    long_thresh  = value;
  endtask

  initial begin
    int plan_thr [5];
    int plan_len [5];
    tick_t t;
    fail_count            = 0;
    steady                = 1'b0;
    rst                  <= 1'b1;
    cfg.valid            <= 1'b0;
    cfg.long_press_ticks <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: lock, arm, deploy, programming with delay wrap, leave.
    write_threshold(8'd1);
    foreach (directed_seq[i]) begin
      t.button = directed_seq[i][1];
      t.launch = directed_seq[i][0];
      pending_ticks.push_back(t);
    end
    wait_idle();

    plan_thr = '{0, 255, int'(LONG_RESET_TICKS), $urandom_range(2, 20), $urandom_range(1, 255)};
    plan_len = '{250, 350, 300, 300, 350};
    foreach (plan_thr[p]) begin
      write_threshold(8'(plan_thr[p]));
      steady = (p == 2);
      build_phase(plan_thr[p], plan_len[p]);
      // hold further ticks until every result of the phase is back
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/racd_pkg.sv
hdl/racd_if.sv
hdl/racd_button.sv
hdl/recovery_arm_and_deploy_controller.sv
dv/tb.sv
